// ===== src/cvm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cvm_pkg
// Shared codes, command struct and saturation helper for the covariance
// vector multiply block.
// ----------------------------------------------------------------------------
package cvm_pkg;

  // Input item kinds, carried on tuser.
  localparam logic [1:0] MODE_FACTOR = 2'd0;
  localparam logic [1:0] MODE_DIAG   = 2'd1;
  localparam logic [1:0] MODE_VECTOR = 2'd2;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  // Covariance forms.
  localparam logic [1:0] COV_SCALAR  = 2'd0;
  localparam logic [1:0] COV_DIAG    = 2'd1;
  localparam logic [1:0] COV_LOWRANK = 2'd2;
  localparam logic [1:0] COV_UNUSED  = 2'd3;

  // Register indexes (byte address is four times the index).
  localparam logic [2:0] REG_COV_TYPE   = 3'd0;
  localparam logic [2:0] REG_LAMBDA     = 3'd1;
  localparam logic [2:0] REG_NUM_POINTS = 3'd2;
  localparam logic [2:0] REG_DIMS       = 3'd3;
  localparam logic [2:0] REG_RANK       = 3'd4;

  // Multiplier operand sources.
  localparam logic [1:0] SRC_LAMBDA   = 2'd0;
  localparam logic [1:0] SRC_DIAG     = 2'd1;
  localparam logic [1:0] SRC_FACT_VEC = 2'd2;
  localparam logic [1:0] SRC_FACT_ACC = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       rd_en;
    logic       mul_en;
    logic [1:0] src;
    logic       acc_en;
    logic       acc_first;
    logic       rank_wr;
    logic       out_load;
    logic       out_sel;
    logic       res_zero;
    logic       out_last;
  } cvm_cmd_t;

  // Clamp a 64-bit signed value to the signed 32-bit range.
  function automatic logic [31:0] sat32(input logic signed [63:0] x);
    logic [31:0] res;
    if (x > 64'sh0000_0000_7FFF_FFFF) begin
      res = 32'h7FFF_FFFF;
    end else if (x < -64'sh0000_0000_8000_0000) begin
      res = 32'h8000_0000;
    end else begin
      res = x[31:0];
    end
    return res;
  endfunction

endpackage

// ===== src/cvm_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cvm_ctrl
// Sequencer for loads, the elementwise pass and the low-rank block passes.
// ----------------------------------------------------------------------------
module cvm_ctrl import cvm_pkg::*; #(
  parameter int MAX_POINTS = 32,
  parameter int MAX_ELEMS  = 64,
  parameter int MAX_RANK   = 8,
  localparam int PW  = $clog2(MAX_POINTS + 1),
  localparam int RW  = $clog2(MAX_RANK + 1),
  localparam int EW  = $clog2(MAX_ELEMS + 1),
  localparam int FD  = MAX_POINTS * MAX_RANK,
  localparam int FAW = (FD > 1) ? $clog2(FD) : 1
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_fire,
  input  logic [1:0]     in_mode,
  input  logic           in_last,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  logic [1:0]     cov_type,
  input  logic [PW-1:0]  n_pts,
  input  logic [RW-1:0]  n_rank,
  input  logic [EW-1:0]  n_elems,
  output cvm_cmd_t       cmd,
  output logic [EW-1:0]  elem,
  output logic [FAW-1:0] fac_addr,
  output logic [RW-1:0]  rank_idx
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_E_RD  = 4'd1;
  localparam logic [3:0] S_E_MUL = 4'd2;
  localparam logic [3:0] S_E_RES = 4'd3;
  localparam logic [3:0] S_A_RD  = 4'd4;
  localparam logic [3:0] S_A_MUL = 4'd5;
  localparam logic [3:0] S_A_ACC = 4'd6;
  localparam logic [3:0] S_B_RD  = 4'd7;
  localparam logic [3:0] S_B_MUL = 4'd8;
  localparam logic [3:0] S_B_ACC = 4'd9;
  localparam logic [3:0] S_B_RES = 4'd10;
  localparam logic [3:0] S_OUT   = 4'd11;

  logic [3:0]    state_r, state_nxt;
  logic [EW-1:0] base_r, base_nxt;
  logic [PW-1:0] i_r, i_nxt;
  logic [RW-1:0] j_r, j_nxt;
  logic          elem_last, pt_last, blk_last, j_last, rank_zero;
  logic [3:0]    blk_start;

  assign elem      = base_r + EW'(i_r);
  assign fac_addr  = FAW'(32'(i_r) * 32'(n_rank) + 32'(j_r));
  assign rank_idx  = j_r;
  assign elem_last = (32'(elem) + 32'd1) == 32'(n_elems);
  assign pt_last   = (32'(i_r) + 32'd1) == 32'(n_pts);
  assign blk_last  = pt_last || elem_last;
  assign j_last    = (32'(j_r) + 32'd1) == 32'(n_rank);
  assign rank_zero = (n_rank == '0);
  assign blk_start = rank_zero ? S_B_RES : S_A_RD;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);

  // Next state and loop counters.
  always_comb begin
    state_nxt = state_r;
    base_nxt  = base_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire && in_mode == MODE_VECTOR && in_last && n_elems != '0) begin
          base_nxt  = '0;
          i_nxt     = '0;
          j_nxt     = '0;
          state_nxt = (cov_type == COV_LOWRANK) ? blk_start : S_E_RD;
        end
      end
      S_E_RD:  state_nxt = S_E_MUL;
      S_E_MUL: state_nxt = S_E_RES;
      S_E_RES: state_nxt = S_OUT;
      S_A_RD:  state_nxt = S_A_MUL;
      S_A_MUL: state_nxt = S_A_ACC;
      S_A_ACC: begin
        if (blk_last) begin
          i_nxt = '0;
          if (j_last) begin
            j_nxt     = '0;
            state_nxt = S_B_RD;
          end else begin
            j_nxt     = j_r + 1'b1;
            state_nxt = S_A_RD;
          end
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = S_A_RD;
        end
      end
      S_B_RD:  state_nxt = S_B_MUL;
      S_B_MUL: state_nxt = S_B_ACC;
      S_B_ACC: begin
        if (j_last) begin
          state_nxt = S_B_RES;
        end else begin
          j_nxt     = j_r + 1'b1;
          state_nxt = S_B_RD;
        end
      end
      S_B_RES: state_nxt = S_OUT;
      S_OUT: begin
        if (out_ready) begin
          if (elem_last) begin
            state_nxt = S_IDLE;
          end else if (cov_type != COV_LOWRANK) begin
            base_nxt  = base_r + 1'b1;
            state_nxt = S_E_RD;
          end else if (pt_last) begin
            base_nxt  = base_r + EW'(n_pts);
            i_nxt     = '0;
            j_nxt     = '0;
            state_nxt = blk_start;
          end else begin
            i_nxt     = i_r + 1'b1;
            j_nxt     = '0;
            state_nxt = rank_zero ? S_B_RES : S_B_RD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath commands decoded from the state.
  always_comb begin
    cmd = '0;
    case (state_r)
      S_E_RD, S_A_RD, S_B_RD: cmd.rd_en = 1'b1;
      S_E_MUL: begin
        cmd.mul_en = 1'b1;
        cmd.src    = (cov_type == COV_SCALAR) ? SRC_LAMBDA : SRC_DIAG;
      end
      S_E_RES: begin
        cmd.out_load = 1'b1;
        cmd.res_zero = (cov_type != COV_SCALAR) && (cov_type != COV_DIAG);
        cmd.out_last = elem_last;
      end
      S_A_MUL: begin
        cmd.mul_en = 1'b1;
        cmd.src    = SRC_FACT_VEC;
      end
      S_A_ACC: begin
        cmd.acc_en    = 1'b1;
        cmd.acc_first = (i_r == '0);
        cmd.rank_wr   = blk_last;
      end
      S_B_MUL: begin
        cmd.mul_en = 1'b1;
        cmd.src    = SRC_FACT_ACC;
      end
      S_B_ACC: begin
        cmd.acc_en    = 1'b1;
        cmd.acc_first = (j_r == '0);
      end
      S_B_RES: begin
        cmd.out_load = 1'b1;
        cmd.out_sel  = 1'b1;
        cmd.res_zero = rank_zero;
        cmd.out_last = elem_last;
      end
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      base_r  <= '0;
      i_r     <= '0;
      j_r     <= '0;
    end else begin
      state_r <= state_nxt;
      base_r  <= base_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
    end
  end

endmodule

// ===== src/cvm_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cvm_dp
// Stores, shared multiplier, accumulator, rank accumulators and the output
// register.
// ----------------------------------------------------------------------------
module cvm_dp import cvm_pkg::*; #(
  parameter int MAX_POINTS = 32,
  parameter int MAX_ELEMS  = 64,
  parameter int MAX_RANK   = 8,
  localparam int RW  = $clog2(MAX_RANK + 1),
  localparam int RAW = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1,
  localparam int EW  = $clog2(MAX_ELEMS + 1),
  localparam int EAW = (MAX_ELEMS > 1) ? $clog2(MAX_ELEMS) : 1,
  localparam int FD  = MAX_POINTS * MAX_RANK,
  localparam int FAW = (FD > 1) ? $clog2(FD) : 1
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_fire,
  input  logic [1:0]     in_mode,
  input  logic [7:0]     in_index,
  input  logic [31:0]    in_value,
  input  logic [31:0]    scale_lambda,
  input  cvm_cmd_t       cmd,
  input  logic [EW-1:0]  elem,
  input  logic [FAW-1:0] fac_addr,
  input  logic [RW-1:0]  rank_idx,
  output logic [5:0]     out_index,
  output logic [31:0]    out_value,
  output logic           out_last
);

  logic [31:0] fac_mem  [FD];
  logic [31:0] diag_mem [MAX_ELEMS];
  logic [31:0] vec_mem  [MAX_ELEMS];

  logic [31:0]        fac_q, diag_q, vec_q;
  logic signed [63:0] rank_acc_r [MAX_RANK];
  logic signed [63:0] prod_r, acc_r, acc_nxt, term;
  logic signed [32:0] op_a;
  logic signed [31:0] op_b;
  logic [31:0]        acc_sat;
  logic [FAW+7:0]     fac_wide;
  logic [EAW+7:0]     elem_wide;
  logic [EW+5:0]      idx_wide;
  logic [RAW-1:0]     rsel;
  logic               fac_we, diag_we, vec_we;

  assign fac_wide  = {{FAW{1'b0}}, in_index};
  assign elem_wide = {{EAW{1'b0}}, in_index};
  assign idx_wide  = {6'b0, elem};
  assign rsel      = rank_idx[RAW-1:0];
  assign fac_we    = in_fire && in_mode == MODE_FACTOR && 32'(in_index) < FD;
  assign diag_we   = in_fire && in_mode == MODE_DIAG && 32'(in_index) < MAX_ELEMS;
  assign vec_we    = in_fire && in_mode == MODE_VECTOR && 32'(in_index) < MAX_ELEMS;

  // Store writes from input transfers, registered reads for the sequencer.
  always_ff @(posedge clk) begin
    if (fac_we) begin
      fac_mem[fac_wide[FAW-1:0]] <= in_value;
    end
    if (cmd.rd_en) begin
      fac_q <= fac_mem[fac_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (diag_we) begin
      diag_mem[elem_wide[EAW-1:0]] <= in_value;
    end
    if (cmd.rd_en) begin
      diag_q <= diag_mem[elem[EAW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (vec_we) begin
      vec_mem[elem_wide[EAW-1:0]] <= in_value;
    end
    if (cmd.rd_en) begin
      vec_q <= vec_mem[elem[EAW-1:0]];
    end
  end

  // Operand selection for the shared multiplier.
  assign acc_sat = sat32(rank_acc_r[rsel]);

  always_comb begin
    case (cmd.src)
      SRC_LAMBDA:   op_a = {1'b0, scale_lambda};
      SRC_DIAG:     op_a = {diag_q[31], diag_q};
      default:      op_a = {fac_q[31], fac_q};
    endcase
    op_b = (cmd.src == SRC_FACT_ACC) ? acc_sat : vec_q;
  end

  // Product register; the full product always fits in 64 bits.
  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_r <= 64'(op_a * op_b);
    end
  end

  assign term    = prod_r >>> 16;
  assign acc_nxt = (cmd.acc_first ? 64'sd0 : acc_r) + term;

  always_ff @(posedge clk) begin
    if (cmd.acc_en) begin
      acc_r <= acc_nxt;
    end
  end

  // Per-column sums of the current block.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < MAX_RANK; k++) begin
        rank_acc_r[k] <= '0;
      end
    end else if (cmd.rank_wr) begin
      rank_acc_r[rsel] <= acc_nxt;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_index <= idx_wide[5:0];
      out_last  <= cmd.out_last;
      if (cmd.res_zero) begin
        out_value <= '0;
      end else if (cmd.out_sel) begin
        out_value <= sat32(acc_r);
      end else begin
        out_value <= sat32(term);
      end
    end
  end

endmodule

// ===== src/covariance_vector_multiply.sv =====
`timescale 1ns / 1ps
// Loads (factor, diagonal, vector) are taken one per clock while the block is idle.
// Scalar and diagonal forms: each output element is read, multiplied, saturated
// and put in the output register, using the single shared multiplier.
// Low rank: per block the column sums come first, then each output element is
// summed over the rank columns; the same multiplier does both.
// Reset (rst_n low, synchronous) restores the register defaults, idles the
// sequencer and clears the rank sums; the stores are not cleared.
// ----------------------------------------------------------------------------
// covariance_vector_multiply
// Q16.16 covariance matrix times vector in scalar, diagonal or low-rank form,
// with a register port and stream input and output channels.
// ----------------------------------------------------------------------------
module covariance_vector_multiply import cvm_pkg::*; #(
  parameter int MAX_POINTS = 32,
  parameter int MAX_ELEMS  = 64,
  parameter int MAX_RANK   = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [7:0] index, [39:8] value
  input  logic [1:0]  in_tuser,   // [1:0] mode
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [5:0] out_index, [37:6] out_value, rest zero
  output logic        out_tlast
);

  localparam int PW  = $clog2(MAX_POINTS + 1);
  localparam int RW  = $clog2(MAX_RANK + 1);
  localparam int EW  = $clog2(MAX_ELEMS + 1);
  localparam int FD  = MAX_POINTS * MAX_RANK;
  localparam int FAW = (FD > 1) ? $clog2(FD) : 1;

  logic [1:0]  cov_type_r;
  logic [31:0] lambda_r;
  logic [5:0]  npts_r;
  logic [3:0]  dims_r;
  logic [3:0]  rank_r;

  logic           cfg_we, in_fire;
  logic [2:0]     reg_sel;
  logic [PW-1:0]  n_pts;
  logic [RW-1:0]  n_rank;
  logic [EW-1:0]  n_elems;
  logic [31:0]    elem_prod;
  cvm_cmd_t       cmd;
  logic [EW-1:0]  elem;
  logic [FAW-1:0] fac_addr;
  logic [RW-1:0]  rank_idx;
  logic [5:0]     res_index;
  logic [31:0]    res_value;

  // Register port.
  assign cfg_pready = 1'b1;
  assign reg_sel    = cfg_paddr[4:2];
  assign cfg_we     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cov_type_r <= COV_SCALAR;
      lambda_r   <= 32'h0001_0000;
      npts_r     <= 6'd32;
      dims_r     <= 4'd2;
      rank_r     <= 4'd1;
    end else if (cfg_we) begin
      case (reg_sel)
        REG_COV_TYPE:   cov_type_r <= cfg_pwdata[1:0];
        REG_LAMBDA:     lambda_r   <= cfg_pwdata;
        REG_NUM_POINTS: npts_r     <= cfg_pwdata[5:0];
        REG_DIMS:       dims_r     <= cfg_pwdata[3:0];
        REG_RANK:       rank_r     <= cfg_pwdata[3:0];
        default:        ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_COV_TYPE:   cfg_prdata = {30'd0, cov_type_r};
      REG_LAMBDA:     cfg_prdata = lambda_r;
      REG_NUM_POINTS: cfg_prdata = {26'd0, npts_r};
      REG_DIMS:       cfg_prdata = {28'd0, dims_r};
      REG_RANK:       cfg_prdata = {28'd0, rank_r};
      default:        cfg_prdata = '0;
    endcase
  end

  // Effective sizes, clamped to the storage bounds.
  assign n_pts     = (32'(npts_r) > MAX_POINTS) ? PW'(MAX_POINTS) : PW'(npts_r);
  assign n_rank    = (32'(rank_r) > MAX_RANK) ? RW'(MAX_RANK) : RW'(rank_r);
  assign elem_prod = 32'(n_pts) * 32'(dims_r);
  assign n_elems   = (elem_prod > MAX_ELEMS) ? EW'(MAX_ELEMS) : EW'(elem_prod);

  assign in_fire = in_tvalid && in_tready;

  cvm_ctrl #(
    .MAX_POINTS(MAX_POINTS),
    .MAX_ELEMS (MAX_ELEMS),
    .MAX_RANK  (MAX_RANK)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .in_mode  (in_tuser),
    .in_last  (in_tlast),
    .in_ready (in_tready),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .cov_type (cov_type_r),
    .n_pts    (n_pts),
    .n_rank   (n_rank),
    .n_elems  (n_elems),
    .cmd      (cmd),
    .elem     (elem),
    .fac_addr (fac_addr),
    .rank_idx (rank_idx)
  );

  cvm_dp #(
    .MAX_POINTS(MAX_POINTS),
    .MAX_ELEMS (MAX_ELEMS),
    .MAX_RANK  (MAX_RANK)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_fire     (in_fire),
    .in_mode     (in_tuser),
    .in_index    (in_tdata[7:0]),
    .in_value    (in_tdata[39:8]),
    .scale_lambda(lambda_r),
    .cmd         (cmd),
    .elem        (elem),
    .fac_addr    (fac_addr),
    .rank_idx    (rank_idx),
    .out_index   (res_index),
    .out_value   (res_value),
    .out_last    (out_tlast)
  );

  assign out_tdata = {2'b00, res_value, res_index};

  // The block never takes input while a result is on offer.
  assert property (@(posedge clk) disable iff (!rst_n) !(in_tready && out_tvalid))
    else $error("input accepted while a result is pending");

  // After the final result transfer the block is ready for input again.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=> in_tready)
    else $error("block not idle after final result");

  // A vector item with last and a nonzero size leads to a busy block.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_tuser == MODE_VECTOR && in_tlast && n_elems != '0) |=> !in_tready)
    else $error("multiply did not start");

endmodule

// ===== tb/sv/cvm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cvm_checker
// Watches the register port and both stream channels of the covariance
// vector multiply block, keeps its own copy of the registers and stores,
// predicts every product element and compares each output transfer with it.
// ----------------------------------------------------------------------------
module cvm_checker import cvm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic        cfg_pready,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [39:0] in_tdata,   // [7:0] index, [39:8] value
  input  logic [1:0]  in_tuser,   // [1:0] mode
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,  // [5:0] out_index, [37:6] out_value, rest zero
  input  logic        out_tlast,
  output int          fail_count,
  output int          pending
);

  typedef struct {
    logic [5:0]  idx;
    logic [31:0] val;
    logic        last;
  } elem_t;

  // Register copies.
  logic [1:0]  cov_sel;
  logic [31:0] lambda_q;
  logic [5:0]  npts;
  logic [3:0]  ndims;
  logic [3:0]  nrank;

  // Store copies.
  logic signed [31:0] factor_mem [256];
  logic signed [31:0] diag_mem [64];
  logic signed [31:0] vec_mem [64];
  longint             rank_sum [8];

  elem_t product_q [$];

  // Q16.16 product with a floor shift.
  function automatic longint q16_mul(input longint a, input longint b);
    return (a * b) >>> 16;
  endfunction

  function automatic longint clamp_q16(input longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint factor_entry(input int row, input int col, input int r);
    int at;
    at = row * r + col;
    if (at >= 256) return 0;
    return longint'(factor_mem[at]);
  endfunction

  // Work out every product element of one multiply and queue it.
  task automatic predict_product();
    int     n, r, nx, b, i, j;
    longint s, lam;
    longint res [64];
    elem_t  e;
    n   = (npts > 32) ? 32 : int'(npts);
    r   = (nrank > 8) ? 8 : int'(nrank);
    nx  = n * int'(ndims);
    lam = longint'({32'd0, lambda_q});
    if (nx > 64) nx = 64;
    if (cov_sel == COV_LOWRANK) begin
      for (b = 0; b < nx; b += n) begin
        for (j = 0; j < r; j++) begin
          s = 0;
          for (i = 0; i < n && b + i < nx; i++) begin
            s += q16_mul(factor_entry(i, j, r), longint'(vec_mem[b + i]));
          end
          rank_sum[j] = s;
        end
        for (i = 0; i < n && b + i < nx; i++) begin
          s = 0;
          for (j = 0; j < r; j++) begin
            s += q16_mul(factor_entry(i, j, r), clamp_q16(rank_sum[j]));
          end
          res[b + i] = clamp_q16(s);
        end
      end
    end else begin
      for (i = 0; i < nx; i++) begin
        case (cov_sel)
          COV_SCALAR: res[i] = clamp_q16(q16_mul(lam, longint'(vec_mem[i])));
          COV_DIAG: res[i] = clamp_q16(q16_mul(longint'(diag_mem[i]),
                                               longint'(vec_mem[i])));
          default: res[i] = 0;
        endcase
      end
    end
    for (i = 0; i < nx; i++) begin
      e.idx  = i[5:0];
      e.val  = res[i][31:0];
      e.last = (i + 1 == nx);
      product_q.push_back(e);
    end
  endtask

  always @(posedge clk) begin
    elem_t      exp_e;
    logic [7:0] idx;
    int         fails;
    if (!rst_n) begin
      cov_sel    <= COV_SCALAR;
      lambda_q   <= 32'd65536;
      npts       <= 6'd32;
      ndims      <= 4'd2;
      nrank      <= 4'd1;
      fail_count <= 0;
      pending    <= 0;
      product_q.delete();
      for (int j = 0; j < 8; j++) rank_sum[j] = 0;
    end else begin
      fails = 0;
      // Register writes.
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[4:2])
          REG_COV_TYPE:   cov_sel  = cfg_pwdata[1:0];
          REG_LAMBDA:     lambda_q = cfg_pwdata;
          REG_NUM_POINTS: npts     = cfg_pwdata[5:0];
          REG_DIMS:       ndims    = cfg_pwdata[3:0];
          REG_RANK:       nrank    = cfg_pwdata[3:0];
          default: ;
        endcase
      end

      // Output transfers against the oldest expectation.
      if (out_tvalid && out_tready) begin
        if (product_q.size() == 0) begin
          $error("unexpected result: out_index %0d out_value %h",
                 out_tdata[5:0], out_tdata[37:6]);
          fails++;
        end else begin
          exp_e = product_q.pop_front();
          if (out_tdata[5:0] !== exp_e.idx) begin
            $error("out_index: expected %0d, got %0d", exp_e.idx, out_tdata[5:0]);
            fails++;
          end
          if (out_tdata[37:6] !== exp_e.val) begin
            $error("out_value: expected %h, got %h", exp_e.val, out_tdata[37:6]);
            fails++;
          end
          if (out_tlast !== exp_e.last) begin
            $error("out_last: expected %0d, got %0d", exp_e.last, out_tlast);
            fails++;
          end
        end
      end

      // Input transfers update the stores; a last vector element multiplies.
      if (in_tvalid && in_tready) begin
        idx = in_tdata[7:0];
        case (in_tuser)
          MODE_FACTOR: factor_mem[idx] = in_tdata[39:8];
          MODE_DIAG: if (idx < 64) diag_mem[idx] = in_tdata[39:8];
          MODE_VECTOR: begin
            if (idx < 64) vec_mem[idx] = in_tdata[39:8];
            if (in_tlast) predict_product();
          end
          default: ;
        endcase
      end
      fail_count <= fail_count + fails;
      pending    <= product_q.size();
    end
  end

endmodule

// ===== tb/sv/tb_covariance_vector_multiply.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_covariance_vector_multiply
// Drives register settings and load/vector streams into the covariance
// vector multiply block under varying back-pressure; the checker beside it
// predicts and compares every product element.
// ----------------------------------------------------------------------------
module tb_covariance_vector_multiply import cvm_pkg::*; ();

  localparam int IDLE_LIMIT   = 40000;
  localparam int TARGET_ITEMS = 450;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [4:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;   // [7:0] index, [39:8] value
  logic [1:0]  in_tuser = '0;   // [1:0] mode
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;       // [5:0] out_index, [37:6] out_value, rest zero
  logic        out_tlast;

  int fail_count;
  int pending;
  int send_idle_pct = 0;
  int stall_pct = 0;
  logic hold_req = 1'b0;
  logic hold_taken = 1'b0;
  int hold_left = 0;
  int idle_cycles = 0;
  int loads_sent = 0;

  // Stimulus-side copy of the registers and of which entries hold data.
  int cur_cov = 0;
  int cur_np = 32;
  int cur_dims = 2;
  int cur_rank = 1;
  bit fac_ok [256];
  bit diag_ok [64];
  bit vec_ok [64];

  covariance_vector_multiply i_dut (.*);

  cvm_checker i_checker (.*);

  initial begin
    forever #2 clk = ~clk;
  end

  // Receiver: random stalls, plus one long hold-off.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (hold_req && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left  <= 4000;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog on cycles without any transfer; results nobody expects do not count.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) ||
        (out_tvalid && out_tready && pending != 0) ||
        (cfg_psel && cfg_penable)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  function automatic logic [31:0] pick_value();
    case ($urandom_range(9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0;
      3: return 32'hFFFF_FFFF;
      4: return $urandom_range(1) ? 32'h0001_0000 : 32'hFFFF_0000;
      5, 6: return $urandom;
      default: return $urandom_range(1) ? $urandom_range(32'h0004_0000)
                                       : -$urandom_range(32'h0004_0000);
    endcase
  endfunction

  task automatic cfg_write(input logic [2:0] reg_idx, input logic [31:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {reg_idx, 2'b00};
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    case (reg_idx)
      REG_COV_TYPE:   cur_cov  = data[1:0];
      REG_NUM_POINTS: cur_np   = data[5:0];
      REG_DIMS:       cur_dims = data[3:0];
      REG_RANK:       cur_rank = data[3:0];
      default: ;
    endcase
  endtask

  // One input transfer, sometimes with a random gap before it.
  task automatic send_item(input logic [1:0] mode, input logic [7:0] idx,
                           input logic [31:0] val, input logic last);
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {val, idx};
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    case (mode)
      MODE_FACTOR: fac_ok[idx] = 1'b1;
      MODE_DIAG: if (idx < 64) diag_ok[idx] = 1'b1;
      MODE_VECTOR: if (idx < 64) vec_ok[idx] = 1'b1;
      default: ;
    endcase
    if (mode != MODE_UNUSED && (idx < 64 || mode == MODE_FACTOR)) loads_sent++;
  endtask

  // Wait until every expected element has come out and the block is quiet.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // Items the block ignores: unknown mode or out-of-range element loads.
  task automatic send_noise();
    case ($urandom_range(2))
      0: send_item(MODE_UNUSED, $urandom, $urandom, $urandom_range(1));
      1: send_item(MODE_DIAG, $urandom_range(64, 255), $urandom, $urandom_range(1));
      default: send_item(MODE_VECTOR, $urandom_range(64, 255), $urandom, 1'b0);
    endcase
  endtask

  task automatic pick_config();
    int sel;
    cfg_write(REG_COV_TYPE, ($urandom_range(9) == 0) ? COV_UNUSED : $urandom_range(2));
    cfg_write(REG_LAMBDA, ($urandom_range(3) == 0) ? 32'h0001_0000 : pick_value());
    sel = $urandom_range(19);
    cfg_write(REG_NUM_POINTS, sel == 0 ? 0 : sel == 1 ? 32 :
              sel == 2 ? $urandom_range(33, 63) : $urandom_range(1, 8));
    sel = $urandom_range(19);
    cfg_write(REG_DIMS, sel == 0 ? 0 : sel == 1 ? 8 :
              sel == 2 ? $urandom_range(9, 15) : $urandom_range(1, 4));
    sel = $urandom_range(19);
    cfg_write(REG_RANK, sel == 0 ? 0 : sel == 1 ? 8 :
              sel == 2 ? $urandom_range(9, 15) : $urandom_range(1, 3));
  endtask

  // Load what the current setting reads, then start the multiply.
  task automatic run_frame();
    int n, r, nx;
    n  = (cur_np > 32) ? 32 : cur_np;
    r  = (cur_rank > 8) ? 8 : cur_rank;
    nx = n * cur_dims;
    if (nx > 64) nx = 64;
    if (cur_cov == COV_LOWRANK) begin
      for (int i = 0; i < n * r; i++) begin
        if (!fac_ok[i] || $urandom_range(1)) begin
          send_item(MODE_FACTOR, i, pick_value(), $urandom_range(1));
        end
      end
    end
    if (cur_cov == COV_DIAG) begin
      for (int i = 0; i < nx; i++) begin
        if (!diag_ok[i] || $urandom_range(1)) begin
          send_item(MODE_DIAG, i, pick_value(), $urandom_range(1));
        end
      end
    end
    for (int i = 0; i < nx; i++) begin
      if ($urandom_range(9) == 0) send_noise();
      if (!vec_ok[i] || $urandom_range(1)) send_item(MODE_VECTOR, i, pick_value(), 1'b0);
    end
    send_item(MODE_VECTOR, ($urandom_range(9) == 0) ? $urandom_range(64, 255)
              : $urandom_range(63), pick_value(), 1'b1);
  endtask

  initial begin
    int frame;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Scalar form with the largest lambda: saturation both ways.
    cfg_write(REG_COV_TYPE, COV_SCALAR);
    cfg_write(REG_LAMBDA, 32'hFFFF_FFFF);
    cfg_write(REG_NUM_POINTS, 4);
    cfg_write(REG_DIMS, 1);
    cfg_write(REG_RANK, 1);
    send_item(MODE_VECTOR, 0, 32'h7FFF_FFFF, 1'b0);
    send_item(MODE_VECTOR, 1, 32'h8000_0000, 1'b0);
    send_item(MODE_VECTOR, 2, 32'h0, 1'b0);
    send_item(MODE_UNUSED, 8'hFF, 32'hFFFF_FFFF, 1'b1);
    send_item(MODE_DIAG, 70, 32'h1234_5678, 1'b0);
    send_item(MODE_VECTOR, 100, 32'h1234_5678, 1'b0);
    send_item(MODE_VECTOR, 3, 32'hFFFF_FFFF, 1'b1);
    drain();

    // Diagonal form; last on a load is ignored, an out-of-range last starts.
    cfg_write(REG_COV_TYPE, COV_DIAG);
    send_item(MODE_DIAG, 0, 32'h7FFF_FFFF, 1'b1);
    send_item(MODE_DIAG, 1, 32'h7FFF_FFFF, 1'b0);
    send_item(MODE_DIAG, 2, 32'h8000_0000, 1'b0);
    send_item(MODE_DIAG, 3, 32'hFFFF_8000, 1'b0);
    send_item(MODE_FACTOR, 255, 32'h0001_0000, 1'b1);
    send_item(MODE_VECTOR, 200, 32'h0, 1'b1);
    drain();

    // Low rank on two blocks of two points, then an unknown form, then empty.
    cfg_write(REG_COV_TYPE, COV_LOWRANK);
    cfg_write(REG_NUM_POINTS, 2);
    cfg_write(REG_DIMS, 2);
    cfg_write(REG_RANK, 2);
    send_item(MODE_FACTOR, 0, 32'h7FFF_FFFF, 1'b0);
    send_item(MODE_FACTOR, 1, 32'h8000_0000, 1'b0);
    send_item(MODE_FACTOR, 2, 32'h0002_0000, 1'b0);
    send_item(MODE_FACTOR, 3, 32'hFFFF_0000, 1'b0);
    send_item(MODE_VECTOR, 3, 32'h7FFF_FFFF, 1'b1);
    drain();
    cfg_write(REG_COV_TYPE, COV_UNUSED);
    send_item(MODE_VECTOR, 0, 32'h0001_0000, 1'b1);
    drain();
    cfg_write(REG_DIMS, 0);
    send_item(MODE_VECTOR, 1, 32'h0001_0000, 1'b1);
    drain();

    // Random frames across the idling phases.
    frame = 0;
    while (loads_sent < TARGET_ITEMS) begin
      case (frame % 4)
        0: begin send_idle_pct = 0;  stall_pct <= 0;  end
        1: begin send_idle_pct = 66; stall_pct <= 0;  end
        2: begin send_idle_pct = 0;  stall_pct <= 66; end
        default: begin send_idle_pct = 13; stall_pct <= 13; end
      endcase
      if (frame == 5) begin
        // Long receiver hold-off: the next frame follows without a pause.
        hold_req <= 1'b1;
      end else if (frame != 6 && (frame < 2 || $urandom_range(1))) begin
        drain();
        pick_config();
      end
      run_frame();
      if (frame != 5 && $urandom_range(3) == 0) drain();
      frame++;
    end
    drain();

    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== covariance_vector_multiply.f =====
src/cvm_pkg.sv
src/cvm_ctrl.sv
src/cvm_dp.sv
src/covariance_vector_multiply.sv
tb/sv/cvm_checker.sv
tb/sv/tb_covariance_vector_multiply.sv
